@@ rtl/nm3_pkg.sv @@
`default_nettype none

package nm3_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int MEAN_BITS      = 24;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 11;

    // Largest magnitude of the mean, 2^23 in units of 1/256.
    localparam logic [MEAN_BITS-1:0] MEAN_TOP = {1'b1, {(MEAN_BITS-1){1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROW_COUNT    = 4'd0,
        REG_COLUMN_COUNT = 4'd1
    } cfg_reg_t;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [MEAN_BITS-1:0] mean;
        logic                        no_neighbours;
        logic                        last;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/neighbour_mean_3x3.sv @@
// Streaming 3x3 neighbour mean, centre excluded. Elements arrive in raster order, one beat per
// clock at full rate; after the last element, one flush beat per column drains the final row.
// Each element reads and writes back one entry of two line memories (one entry per column);
// the read data is registered and is bypassed from the previous beat when the matrix is
// one column wide. A result passes the stage registers s1 to s5 after the beat that completes
// its window and is queued in a 16-entry result queue; in_ready drops only while results
// already owed to accepted beats would fill that queue, so with out_ready held high the block
// takes one beat every cycle. A configuration write restarts the matrix and must be issued
// while the block is idle.
`default_nettype none

module neighbour_mean_3x3 #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nm3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [nm3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  nm3_pkg::in_item_t                    in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output nm3_pkg::out_item_t                   out_item
);
    import nm3_pkg::*;

    localparam int CW          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW          = $clog2(MAX_ROWS + 1);
    localparam int SUM_BITS    = VALUE_BITS + 3;
    localparam int MAG_BITS    = SUM_BITS;
    localparam int RECIP_BITS  = 21;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
    localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
    localparam int WIDE_BITS   = MAG_BITS + 8;
    localparam int QDEPTH      = 16;
    localparam int QW          = $clog2(QDEPTH);
    localparam int CNT_BITS    = QW + 1;

    localparam logic [RECIP_BITS-1:0] RECIP_THREE = 21'd1398102;
    localparam logic [RECIP_BITS-1:0] RECIP_FIVE  = 21'd838861;

    typedef logic signed [VALUE_BITS-1:0] window_t [3][3];

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [2:0] cols;
    } lane_sel_t;

    typedef struct packed {
        logic                       emit;
        logic                       last;
        logic [3:0]                 count;
        logic signed [SUM_BITS-1:0] sum;
    } lane_sum_t;

    typedef struct packed {
        logic                emit;
        logic                last;
        logic [3:0]          count;
        logic                neg;
        logic [MAG_BITS-1:0] mag;
    } lane_mag_t;

    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [3:0]           count;
        logic                 neg;
        logic [MAG_BITS-1:0]  mag;
        logic [PROD_BITS-1:0] prod;
    } lane_prod_t;

    function automatic lane_sum_t lane_sum(input lane_sel_t sel, input logic [2:0] rows,
                                           input int centre, input window_t win);
        lane_sum_t                  res;
        logic [3:0]                 cnt;
        logic signed [SUM_BITS-1:0] acc;
        cnt = '0;
        acc = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (rows[i] && sel.cols[j] && !(i == 1 && j == centre))
                begin
                    acc = acc + SUM_BITS'(win[i][j]);
                    cnt = cnt + 4'd1;
                end
            end
        end
        res.emit  = sel.emit;
        res.last  = sel.last;
        res.count = cnt;
        res.sum   = acc;
        return res;
    endfunction

    function automatic lane_mag_t lane_mag(input lane_sum_t s);
        lane_mag_t res;
        res.emit  = s.emit;
        res.last  = s.last;
        res.count = s.count;
        res.neg   = s.sum < 0;
        res.mag   = res.neg ? MAG_BITS'(-s.sum) : MAG_BITS'(s.sum);
        return res;
    endfunction

    function automatic lane_prod_t lane_prod(input lane_mag_t m);
        lane_prod_t            res;
        logic [RECIP_BITS-1:0] recip;
        recip     = (m.count == 4'd3) ? RECIP_THREE : RECIP_FIVE;
        res.emit  = m.emit;
        res.last  = m.last;
        res.count = m.count;
        res.neg   = m.neg;
        res.mag   = m.mag;
        res.prod  = PROD_BITS'(m.mag) * PROD_BITS'(recip);
        return res;
    endfunction

    // Rounded fraction of (256 * remainder + divisor / 2) / divisor, in 1/256 units.
    function automatic logic [7:0] round_frac(input logic by_three, input logic [2:0] rem);
        logic [7:0] f;
        f = '0;
        if (by_three)
        begin
            case (rem)
                3'd1:    f = 8'd85;
                3'd2:    f = 8'd171;
                default: f = '0;
            endcase
        end
        else
        begin
            case (rem)
                3'd1:    f = 8'd51;
                3'd2:    f = 8'd102;
                3'd3:    f = 8'd154;
                3'd4:    f = 8'd205;
                default: f = '0;
            endcase
        end
        return f;
    endfunction

    function automatic out_item_t lane_mean(input lane_prod_t p);
        out_item_t             res;
        logic                  by_three;
        logic [QUOT_BITS-1:0]  quot;
        logic [MAG_BITS-1:0]   back;
        logic [2:0]            rem;
        logic [WIDE_BITS-1:0]  wide;
        logic [MEAN_BITS-1:0]  q;
        by_three = (p.count == 4'd3);
        quot     = p.prod[RECIP_SHIFT +: QUOT_BITS];
        back     = by_three ? (MAG_BITS'(quot) << 1) + MAG_BITS'(quot)
                            : (MAG_BITS'(quot) << 2) + MAG_BITS'(quot);
        rem      = 3'(p.mag - back);
        case (p.count)
            4'd1:       wide = WIDE_BITS'({p.mag, 8'b0});
            4'd2:       wide = WIDE_BITS'({p.mag, 7'b0});
            4'd8:       wide = WIDE_BITS'({p.mag, 5'b0});
            4'd3, 4'd5: wide = WIDE_BITS'({quot, 8'b0}) + WIDE_BITS'(round_frac(by_three, rem));
            default:    wide = '0;
        endcase
        q = (wide > WIDE_BITS'(MEAN_TOP)) ? MEAN_TOP : MEAN_BITS'(wide);
        if (p.neg)
        begin
            res.mean = -q;
        end
        else
        begin
            res.mean = (q == MEAN_TOP) ? MEAN_TOP - 1'b1 : q;
        end
        res.no_neighbours = (p.count == 4'd0);
        res.last          = p.last;
        return res;
    endfunction

    // Configuration and stream position.
    logic [RW-1:0]       rows_eff_reg;
    logic [CW-1:0]       cols_last_reg;
    logic [RW-1:0]       row_reg;
    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       rows_cfg;
    logic [CW-1:0]       cols_last_cfg;
    logic                cfg_write;
    logic                flush_due;
    logic                take;
    logic                is_flush;

    // Line memories and read bypass.
    logic signed [VALUE_BITS-1:0] upper_mem [MAX_COLUMNS];
    logic signed [VALUE_BITS-1:0] middle_mem [MAX_COLUMNS];
    logic signed [VALUE_BITS-1:0] upper_rd_reg;
    logic signed [VALUE_BITS-1:0] middle_rd_reg;
    logic signed [VALUE_BITS-1:0] fwd_upper_reg;
    logic signed [VALUE_BITS-1:0] fwd_middle_reg;
    logic                         fwd_reg;
    logic signed [VALUE_BITS-1:0] upper_eff;
    logic signed [VALUE_BITS-1:0] middle_eff;

    // Pipeline.
    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                         s4_valid_reg, s5_valid_reg;
    logic                         s1_flush_reg;
    logic [CW-1:0]                s1_col_reg;
    logic signed [VALUE_BITS-1:0] s1_cur_reg;
    logic [2:0]                   s1_rows_reg, s2_rows_reg;
    lane_sel_t                    s1_a_reg, s1_b_reg, s2_a_reg, s2_b_reg;
    lane_sel_t                    sel_a, sel_b;
    logic [2:0]                   rows_now;
    lane_sum_t                    s3_a_reg, s3_b_reg;
    lane_mag_t                    s4_a_reg, s4_b_reg;
    lane_prod_t                   s5_a_reg, s5_b_reg;
    window_t                      window_reg;
    out_item_t                    res_a, res_b;

    // Result queue.
    out_item_t           queue_mem [QDEPTH];
    logic [QW-1:0]       wp_reg, rp_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] owed_reg, owed_next;
    logic                push_a, push_b, pop;
    logic [1:0]          new_results;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            rows_cfg = RW'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_ROWS))
        begin
            rows_cfg = RW'(MAX_ROWS);
        end
        else
        begin
            rows_cfg = RW'(cfg_data);
        end
        if (cfg_data == '0)
        begin
            cols_last_cfg = '0;
        end
        else if (32'(cfg_data) > 32'(MAX_COLUMNS))
        begin
            cols_last_cfg = CW'(MAX_COLUMNS - 1);
        end
        else
        begin
            cols_last_cfg = CW'(cfg_data - 1'b1);
        end
    end

    // Elements are taken while rows remain, flush beats once every row is in.
    assign flush_due = (row_reg == rows_eff_reg);
    assign is_flush  = (in_item.kind == KIND_FLUSH);
    assign in_ready  = (owed_reg < CNT_BITS'(QDEPTH - 1));
    assign take      = in_valid && in_ready &&
                       (in_item.kind == (flush_due ? KIND_FLUSH : KIND_ELEMENT));

    // Window rows and columns that lie inside the matrix for the two possible results.
    always_comb
    begin
        rows_now   = {!is_flush, 1'b1, row_reg > RW'(1)};
        sel_a.emit = (row_reg != '0) && (col_reg != '0);
        sel_a.last = 1'b0;
        sel_a.cols = {1'b1, 1'b1, col_reg > CW'(1)};
        sel_b.emit = (row_reg != '0) && (col_reg == cols_last_reg);
        sel_b.last = is_flush;
        sel_b.cols = {1'b1, col_reg != '0, 1'b0};
    end

    assign new_results = {1'b0, sel_a.emit} + {1'b0, sel_b.emit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_eff_reg  <= RW'(1);
            cols_last_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_COUNT:
                begin
                    rows_eff_reg <= rows_cfg;
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
                REG_COLUMN_COUNT:
                begin
                    cols_last_reg <= cols_last_cfg;
                    row_reg       <= '0;
                    col_reg       <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (take)
        begin
            if (col_reg == cols_last_reg)
            begin
                col_reg <= '0;
                row_reg <= is_flush ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    assign upper_eff  = fwd_reg ? fwd_upper_reg : upper_rd_reg;
    assign middle_eff = fwd_reg ? fwd_middle_reg : middle_rd_reg;

    // Read at acceptance, write back in the following cycle from the stage-one element beat.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
        if (s1_valid_reg && !s1_flush_reg)
        begin
            upper_mem[s1_col_reg]  <= middle_eff;
            middle_mem[s1_col_reg] <= s1_cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                fwd_reg <= s1_valid_reg && !s1_flush_reg && (s1_col_reg == col_reg);
            end
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fwd_upper_reg  <= middle_eff;
            fwd_middle_reg <= s1_cur_reg;
            s1_flush_reg   <= is_flush;
            s1_col_reg     <= col_reg;
            s1_cur_reg     <= is_flush ? '0 : in_item.value;
            s1_rows_reg    <= rows_now;
            s1_a_reg       <= sel_a;
            s1_b_reg       <= sel_b;
        end
        if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                window_reg[i][0] <= window_reg[i][1];
                window_reg[i][1] <= window_reg[i][2];
            end
            window_reg[0][2] <= upper_eff;
            window_reg[1][2] <= middle_eff;
            window_reg[2][2] <= s1_cur_reg;
        end
        s2_rows_reg <= s1_rows_reg;
        s2_a_reg    <= s1_a_reg;
        s2_b_reg    <= s1_b_reg;
        s3_a_reg    <= lane_sum(s2_a_reg, s2_rows_reg, 1, window_reg);
        s3_b_reg    <= lane_sum(s2_b_reg, s2_rows_reg, 2, window_reg);
        s4_a_reg    <= lane_mag(s3_a_reg);
        s4_b_reg    <= lane_mag(s3_b_reg);
        s5_a_reg    <= lane_prod(s4_a_reg);
        s5_b_reg    <= lane_prod(s4_b_reg);
    end

    assign res_a  = lane_mean(s5_a_reg);
    assign res_b  = lane_mean(s5_b_reg);
    assign push_a = s5_valid_reg && s5_a_reg.emit;
    assign push_b = s5_valid_reg && s5_b_reg.emit;
    assign pop    = out_valid && out_ready;

    assign out_valid = (cnt_reg != '0);
    assign out_item  = queue_mem[rp_reg];

    // Results owed counts both queued results and those still in the pipeline.
    always_comb
    begin
        cnt_next  = cnt_reg + CNT_BITS'(push_a) + CNT_BITS'(push_b) - CNT_BITS'(pop);
        owed_next = owed_reg - CNT_BITS'(pop);
        if (take)
        begin
            owed_next = owed_next + CNT_BITS'(new_results);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            queue_mem[wp_reg] <= res_a;
        end
        if (push_b)
        begin
            queue_mem[push_a ? wp_reg + QW'(1) : wp_reg] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            owed_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_reg + QW'(push_a) + QW'(push_b);
            rp_reg   <= rp_reg + QW'(pop);
            cnt_reg  <= cnt_next;
            owed_reg <= owed_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nm3_checker.sv @@
`default_nettype none

module nm3_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input nm3_pkg::out_item_t out_item
);
    import nm3_pkg::*;

    // A beat that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

    // A position without neighbours always reports a zero mean.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.no_neighbours |-> out_item.mean == '0)
    else $error("nonzero mean with no neighbours");

    // The mean of 16-bit elements never exceeds 32767 in its integer part.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.mean[MEAN_BITS-1] |->
            out_item.mean[MEAN_BITS-2:0] <= 23'h7F_FF00)
    else $error("positive mean above the element range");

    // Coming out of reset the queue is empty and input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind neighbour_mean_3x3 nm3_checker u_nm3_checker (.*);

`default_nettype wire

@@ bench/neighbour_mean_checker.sv @@
`timescale 1ns / 100ps

// Keeps its own copy of the line memories, the window and the raster position, and checks
// every result beat against the oldest result that is still due.
module neighbour_mean_checker
    import nm3_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  in_item_t                  in_item,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  out_item_t                 out_item,
    output int                        fail_count,
    output int                        pending_results,
    output int                        results_checked
);

    logic [CFG_DATA_BITS-1:0]     rows_setting;
    logic [CFG_DATA_BITS-1:0]     cols_setting;
    logic signed [VALUE_BITS-1:0] upper_row [MAX_COLUMNS];
    logic signed [VALUE_BITS-1:0] middle_row [MAX_COLUMNS];
    logic signed [VALUE_BITS-1:0] window [3][3];
    int                           row_pos;
    int                           col_pos;
    out_item_t                    means_due [$];

    function automatic void restart_matrix();
        row_pos = 0;
        col_pos = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                window[i][j] = '0;
    endfunction

    function automatic int used_size(logic [CFG_DATA_BITS-1:0] setting, int ceiling);
        if (setting == 0)
            return 1;
        if (setting > ceiling)
            return ceiling;
        return int'(setting);
    endfunction

    // Mean of the in-bounds neighbours of the centre held in window column centre_col.
    // r and c are the stream position of the beat that completed the window.
    function automatic out_item_t centre_mean(int r, int c, int nr, int nc, int centre_col,
                                             logic is_last);
        longint    total;
        longint    mag;
        longint    q;
        longint    top;
        int        n;
        int        ar;
        int        ac;
        logic      neg;
        out_item_t res;
        total = 0;
        n = 0;
        top = longint'(MEAN_TOP);
        for (int i = 0; i < 3; i++)
        begin
            ar = r - 2 + i;
            if (ar < 0 || ar >= nr)
                continue;
            for (int j = centre_col - 1; j <= centre_col + 1 && j <= 2; j++)
            begin
                ac = c - 2 + j;
                if (ac < 0 || ac >= nc || (i == 1 && j == centre_col))
                    continue;
                total += longint'(window[i][j]);
                n++;
            end
        end
        res.mean = '0;
        if (n != 0)
        begin
            neg = (total < 0);
            mag = neg ? -total : total;
            // Round half away from zero on the magnitude, then saturate.
            q = (mag * 512 + n) / (2 * n);
            if (q > top)
                q = top;
            if (neg)
                res.mean = -q;
            else
                res.mean = (q >= top) ? top - 1 : q;
        end
        res.no_neighbours = (n == 0);
        res.last = is_last;
        return res;
    endfunction

    function automatic void write_register(logic [CFG_INDEX_BITS-1:0] index,
                                           logic [CFG_DATA_BITS-1:0] data);
        case (index)
            REG_ROW_COUNT:
            begin
                rows_setting = data;
                restart_matrix();
            end
            REG_COLUMN_COUNT:
            begin
                cols_setting = data;
                restart_matrix();
            end
            default:
                ;
        endcase
    endfunction

    function automatic void take_beat(in_item_t beat);
        int                           nr;
        int                           nc;
        int                           r;
        int                           c;
        logic                         is_flush;
        logic signed [VALUE_BITS-1:0] above;
        logic signed [VALUE_BITS-1:0] mid;
        nr = used_size(rows_setting, MAX_ROWS);
        nc = used_size(cols_setting, MAX_COLUMNS);
        is_flush = (beat.kind == KIND_FLUSH);
        r = row_pos;
        c = col_pos;
        // A beat of the wrong kind for this point of the matrix is dropped.
        if (is_flush != (r >= nr))
            return;
        if (c >= nc)
            c = 0;
        above = upper_row[c];
        mid = middle_row[c];
        for (int i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = above;
        window[1][2] = mid;
        window[2][2] = is_flush ? '0 : beat.value;
        if (!is_flush)
        begin
            upper_row[c] = mid;
            middle_row[c] = beat.value;
        end
        if (r >= 1)
        begin
            if (c >= 1)
                means_due.push_back(centre_mean(r, c, nr, nc, 1, 1'b0));
            if (c == nc - 1)
                means_due.push_back(centre_mean(r, c, nr, nc, 2, is_flush));
        end
        if (c + 1 >= nc)
        begin
            if (is_flush)
                restart_matrix();
            else
            begin
                row_pos = r + 1;
                col_pos = 0;
            end
        end
        else
            col_pos = c + 1;
    endfunction

    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (means_due.size() == 0)
        begin
            fail_count++;
            $display("%0t: result beat with none due: mean %0d no_neighbours %0b last %0b",
                     $time, $signed(got.mean), got.no_neighbours, got.last);
            return;
        end
        want = means_due.pop_front();
        results_checked++;
        if (got !== want)
        begin
            fail_count++;
            if (got.mean !== want.mean)
                $display("%0t: result %0d mean expected %0d actual %0d", $time,
                         results_checked, $signed(want.mean), $signed(got.mean));
            if (got.no_neighbours !== want.no_neighbours)
                $display("%0t: result %0d no_neighbours expected %0b actual %0b", $time,
                         results_checked, want.no_neighbours, got.no_neighbours);
            if (got.last !== want.last)
                $display("%0t: result %0d last expected %0b actual %0b", $time,
                         results_checked, want.last, got.last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_setting = 1;
            cols_setting = 1;
            for (int a = 0; a < MAX_COLUMNS; a++)
            begin
                upper_row[a] = '0;
                middle_row[a] = '0;
            end
            restart_matrix();
            means_due.delete();
            fail_count = 0;
            results_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_item);
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                take_beat(in_item);
        end
        pending_results = means_due.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import nm3_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int RANDOM_ITEMS  = 950;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int WHOLE         = 1 << 30;
    localparam int CYCLE_LIMIT   = 1500000;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    in_item_t                  in_item;
    logic                      out_valid;
    logic                      out_ready;
    out_item_t                 out_item;

    int fail_count;
    int pending_results;
    int results_checked;

    int                       cycle_count = 0;
    int                       items_sent = 0;
    int                       setups = 0;
    int                       send_calm = 0;
    int                       recv_calm = 0;
    int                       rows_now = 1;
    int                       cols_now = 1;
    logic [CFG_DATA_BITS-1:0] rows_written = 1;
    logic [CFG_DATA_BITS-1:0] cols_written = 1;
    bit                       matrix_open = 0;
    logic                     hold_request;

    neighbour_mean_3x3 #(
        .MAX_COLUMNS(MAX_DIM),
        .MAX_ROWS   (MAX_DIM)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    neighbour_mean_checker #(
        .MAX_COLUMNS(MAX_DIM),
        .MAX_ROWS   (MAX_DIM)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .fail_count     (fail_count),
        .pending_results(pending_results),
        .results_checked(results_checked)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly random gaps, with occasional stretches of back-to-back beats.
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_size(int ceiling);
        case ($urandom_range(0, 11))
            0: return '0;
            1: return 1;
            default: return $urandom_range(1, ceiling);
        endcase
    endfunction

    function automatic int used_size(logic [CFG_DATA_BITS-1:0] setting);
        return (setting == 0) ? 1 : (setting > MAX_DIM) ? MAX_DIM : int'(setting);
    endfunction

    // All tasks start and end at a falling edge.
    task automatic send_beat(input logic kind, input logic signed [VALUE_BITS-1:0] value);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.kind = kind;
        in_item.value = value;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index = index;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Beats that produce no result may still be in the pipeline when the last result leaves,
    // so the block is given its full latency before it counts as idle.
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_bogus_index();
        write_cfg($urandom_range(REG_COLUMN_COUNT + 1, (1 << CFG_INDEX_BITS) - 1), $urandom);
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] rows_val,
                             input logic [CFG_DATA_BITS-1:0] cols_val);
        bit do_rows;
        bit do_cols;
        bit cols_first;
        wait_quiet();
        do_rows = (rows_val != rows_written) || $urandom_range(0, 1);
        do_cols = (cols_val != cols_written) || !do_rows || $urandom_range(0, 1);
        cols_first = $urandom_range(0, 1);
        if (cols_first && do_cols)
            write_cfg(REG_COLUMN_COUNT, cols_val);
        if (do_rows)
            write_cfg(REG_ROW_COUNT, rows_val);
        if (!cols_first && do_cols)
            write_cfg(REG_COLUMN_COUNT, cols_val);
        rows_written = rows_val;
        cols_written = cols_val;
        rows_now = used_size(rows_val);
        cols_now = used_size(cols_val);
        matrix_open = 0;
        setups++;
    endtask

    // Streams one matrix in raster order followed by its flush beats, stopping after cap
    // well-formed beats. Out-of-turn beats and idle pauses with a write to an unused register
    // are mixed in; neither of them disturbs the matrix.
    task automatic run_matrix(input int cap, input int hold_at);
        int elements;
        int total;
        int k;
        elements = rows_now * cols_now;
        total = elements + cols_now;
        if (cap > total)
            cap = total;
        k = 0;
        while (k < cap)
        begin
            if (k == hold_at)
            begin
                hold_request = 1'b1;
                hold_at = -1;
            end
            if ($urandom_range(0, 39) == 0)
                send_beat((k < elements) ? KIND_FLUSH : KIND_ELEMENT, random_value());
            else if ($urandom_range(0, 79) == 0)
            begin
                wait_quiet();
                write_bogus_index();
            end
            else
            begin
                send_beat((k < elements) ? KIND_ELEMENT : KIND_FLUSH, random_value());
                k++;
                items_sent++;
            end
        end
        matrix_open = (cap < total);
    endtask

    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int random_start;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // After reset the matrix is a single element: a flush before it and a second element
        // after it are dropped, and its result has no neighbours.
        send_beat(KIND_FLUSH, VALUE_MAX);
        send_beat(KIND_ELEMENT, VALUE_MAX);
        send_beat(KIND_ELEMENT, VALUE_MIN);
        send_beat(KIND_FLUSH, '0);
        items_sent = 4;

        // A 3x3 matrix whose centre is surrounded by the most negative value gives the
        // bottom of the mean range.
        wait_quiet();
        write_bogus_index();
        configure(3, 3);
        for (int k = 0; k < 9; k++)
            send_beat(KIND_ELEMENT, (k == 4) ? VALUE_MAX : VALUE_MIN);
        for (int k = 0; k < 3; k++)
            send_beat(KIND_FLUSH, '0);
        items_sent += 12;

        // The tallest and widest matrices; the receiver stalls during the wide one.
        configure('1, 1);
        run_matrix(WHOLE, -1);
        configure(2, MAX_DIM);
        run_matrix(WHOLE, MAX_DIM + 80);
        configure(MAX_DIM + 1, 4);
        run_matrix(40, -1);
        configure(3, '1);
        run_matrix(40, -1);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (matrix_open || $urandom_range(0, 2) != 0)
                configure(pick_size(7), pick_size(9));
            if ($urandom_range(0, 6) == 0)
                run_matrix($urandom_range(1, rows_now * cols_now + cols_now - 1), -1);
            else
                run_matrix(WHOLE, -1);
        end

        wait_quiet();
        $display("Streamed %0d matrix beats over %0d register setups, sizes from 1x1 up to",
                 items_sent, setups);
        $display("1024 rows or columns, with one long output stall; %0d results checked.",
                 results_checked);
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
